@@ rtl/keypoint_grid_occupancy_check_defines.svh @@
// Assertion macros shared by the keypoint grid occupancy check RTL.
`ifndef KEYPOINT_GRID_OCCUPANCY_CHECK_DEFINES_SVH
`define KEYPOINT_GRID_OCCUPANCY_CHECK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KGOC_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KGOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/kgoc_pkg.sv @@
// Types and constants shared by the keypoint grid occupancy check modules.
package kgoc_pkg;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 12;
    localparam int DIM_W      = 13;
    localparam int THRESH_W   = 16;
    localparam int OCC_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_W      = 13;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam logic [CMD_W-1:0] CMD_BEGIN    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_KEYPOINT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH       = 2'd3;

    localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [DIM_W-1:0]    RST_CELL_SIZE    = 13'd32;
    localparam logic [THRESH_W-1:0] RST_THRESH       = 16'd32768;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

@@ rtl/kgoc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kgoc_ram #(
    parameter  int WIDTH = 1,
    parameter  int DEPTH = 4096,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/kgoc_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module kgoc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kgoc_pkg::t_div_req i_req,
    output kgoc_pkg::t_div_rsp o_rsp
);
    import kgoc_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_div;

    logic [DIV_W:0]       shifted;
    logic [DIV_W:0]       diff;
    logic                 fits;

    // The quotient register starts out holding the dividend; its top bit
    // moves into the partial remainder as each quotient bit moves in below.
    assign shifted = {r_rem, r_quo[DIV_W-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_div  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], fits};
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

@@ rtl/keypoint_grid_occupancy_check.sv @@
// Top level of the keypoint grid occupancy check: sequencer, registers and grid bitmap.
// The block keeps a bitmap of GRID_SIDE_MAX x GRID_SIDE_MAX grid cells in a RAM and
// handles one command word at a time; o_stall is high until the current command is done.
// All divisions run on one shared 13-step radix-2 divider. A keypoint takes two
// divisions (column and row) plus, if it lies inside the grid, a read-modify-write of
// its bitmap bit. The column and row counts of the grid are cached: the first keypoint
// or evaluate after a write to image_width, image_height or cell_size (and after reset)
// spends two more divisions to refresh them. Evaluate takes two registered multiplies
// and a compare and returns one result word. Begin, and reset itself, clear the bitmap
// in a pass over all GRID_SIDE_MAX * GRID_SIDE_MAX cells (4096 at the default size),
// one cell per cycle, during which no command word is taken; configuration writes are
// taken at any time.
`include "keypoint_grid_occupancy_check_defines.svh"

module keypoint_grid_occupancy_check #(
    parameter int GRID_SIDE_MAX = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [kgoc_pkg::CMD_W-1:0]      i_cmd,
    input  logic [kgoc_pkg::COORD_W-1:0]    i_kp_x,
    input  logic [kgoc_pkg::COORD_W-1:0]    i_kp_y,

    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_good_distribution,
    output logic [kgoc_pkg::OCC_W-1:0]      o_occupied_count,
    output logic [kgoc_pkg::OCC_W-1:0]      o_grid_total,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kgoc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kgoc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kgoc_pkg::*;

    localparam int SW    = $clog2(GRID_SIDE_MAX + 1);
    localparam int DEPTH = GRID_SIDE_MAX * GRID_SIDE_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = 2 * SW;
    localparam int PW    = THRESH_W + TW;
    localparam int OW    = OCC_W + 16;
    localparam int CW    = (PW > OW) ? PW : OW;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_W,
        S_DIV_H,
        S_DIV_X,
        S_DIV_Y,
        S_RD,
        S_MARK,
        S_TOT,
        S_MUL,
        S_OUT
    } t_state;

    // Configuration registers.
    logic [DIM_W-1:0]    r_image_width;
    logic [DIM_W-1:0]    r_image_height;
    logic [DIM_W-1:0]    r_cell_size;
    logic [THRESH_W-1:0] r_thresh;

    // Sequencer state and working registers.
    t_state              r_state;
    logic                r_issued;
    logic                r_geom_stale;
    logic [CMD_W-1:0]    r_cmd;
    logic [COORD_W-1:0]  r_x;
    logic [COORD_W-1:0]  r_y;
    logic [SW-1:0]       r_cols;
    logic [SW-1:0]       r_rows;
    logic [DIV_W-1:0]    r_col_q;
    logic [AW-1:0]       r_addr;
    logic [AW-1:0]       r_clr_addr;
    logic [OCC_W-1:0]    r_count;
    logic [TW-1:0]       r_total;
    logic [PW-1:0]       r_prod;

    // Output word.
    logic                r_out_valid;
    logic                r_good;
    logic [OCC_W-1:0]    r_occ_out;
    logic [OCC_W-1:0]    r_total_out;

    logic                cfg_wr;
    logic                geom_wr;
    logic                out_free;
    logic [SW-1:0]       side_q;
    logic                in_grid;
    logic                good;
    logic                new_mark;
    logic                div_state;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic                ram_wdata;
    logic                ram_re;
    logic                ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign geom_wr     = cfg_wr && (i_cfg_index == CFG_IMAGE_WIDTH ||
                                    i_cfg_index == CFG_IMAGE_HEIGHT ||
                                    i_cfg_index == CFG_CELL_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_cell_size    <= RST_CELL_SIZE;
            r_thresh       <= RST_THRESH;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                CFG_CELL_SIZE:    r_cell_size    <= i_cfg_data[DIM_W-1:0];
                CFG_THRESH:       r_thresh       <= i_cfg_data[THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    kgoc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = r_cell_size;
        case (r_state)
            S_DIV_W: begin
                div_req.start    = !r_issued;
                div_req.dividend = r_image_width;
            end
            S_DIV_H: begin
                div_req.start    = !r_issued;
                div_req.dividend = r_image_height;
            end
            S_DIV_X: begin
                div_req.start    = !r_issued;
                div_req.dividend = DIV_W'(r_x);
            end
            S_DIV_Y: begin
                div_req.start    = !r_issued;
                div_req.dividend = DIV_W'(r_y);
            end
            default: ;
        endcase
    end

    // Grid side from a quotient: no cells for a zero cell size, else capped.
    assign side_q = (r_cell_size == '0) ? '0 :
                    (div_rsp.quotient > DIV_W'(GRID_SIDE_MAX)) ? SW'(GRID_SIDE_MAX) :
                    div_rsp.quotient[SW-1:0];

    assign in_grid = (r_col_q < DIV_W'(r_cols)) && (div_rsp.quotient < DIV_W'(r_rows));

    kgoc_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign new_mark  = (r_state == S_MARK) && !ram_rdata;
    assign div_state = (r_state == S_DIV_W) || (r_state == S_DIV_H) ||
                       (r_state == S_DIV_X) || (r_state == S_DIV_Y);

    assign ram_we    = (r_state == S_CLEAR) || new_mark;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign ram_wdata = (r_state == S_MARK);
    assign ram_re    = (r_state == S_RD);

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign good     = (r_total != '0) && (CW'({r_count, 16'b0}) > CW'(r_prod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_issued     <= 1'b0;
            r_geom_stale <= 1'b1;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // A new word loaded in S_OUT takes the place of the one leaving.
            if (r_out_valid && !i_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (geom_wr) begin
                r_geom_stale <= 1'b1;
            end
            if (div_req.start) begin
                r_issued <= 1'b1;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_x   <= i_kp_x;
                        r_y   <= i_kp_y;
                        unique case (i_cmd)
                            CMD_BEGIN: begin
                                r_count    <= '0;
                                r_clr_addr <= '0;
                                r_state    <= S_CLEAR;
                            end
                            CMD_KEYPOINT: begin
                                r_state <= (r_geom_stale || geom_wr) ? S_DIV_W : S_DIV_X;
                            end
                            CMD_EVAL: begin
                                r_state <= (r_geom_stale || geom_wr) ? S_DIV_W : S_TOT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV_W: begin
                    if (div_rsp.done) begin
                        r_cols   <= side_q;
                        r_issued <= 1'b0;
                        r_state  <= S_DIV_H;
                    end
                end
                S_DIV_H: begin
                    if (div_rsp.done) begin
                        r_rows   <= side_q;
                        r_issued <= 1'b0;
                        if (!geom_wr) begin
                            r_geom_stale <= 1'b0;
                        end
                        r_state  <= (r_cmd == CMD_EVAL) ? S_TOT : S_DIV_X;
                    end
                end
                S_DIV_X: begin
                    if (div_rsp.done) begin
                        r_col_q  <= div_rsp.quotient;
                        r_issued <= 1'b0;
                        r_state  <= S_DIV_Y;
                    end
                end
                S_DIV_Y: begin
                    if (div_rsp.done) begin
                        r_issued <= 1'b0;
                        r_addr   <= AW'(div_rsp.quotient[SW-1:0]) * AW'(GRID_SIDE_MAX) +
                                    AW'(r_col_q[SW-1:0]);
                        // A keypoint beyond the grid, or any keypoint with a zero
                        // cell size, leaves the bitmap alone.
                        r_state  <= in_grid ? S_RD : S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_MARK;
                end
                S_MARK: begin
                    if (!ram_rdata) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_TOT: begin
                    r_total <= TW'(r_cols) * TW'(r_rows);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= PW'(r_thresh) * PW'(r_total);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_good      <= good;
                        r_occ_out   <= r_count;
                        r_total_out <= OCC_W'(r_total);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_out_valid;
    assign o_good_distribution = r_good;
    assign o_occupied_count    = r_occ_out;
    assign o_grid_total        = r_total_out;

    `KGOC_ASSERT_NEXT(a_new_mark_counts, i_clk, i_rst_n, new_mark, r_count == $past(r_count) + 1'b1, "new mark missed")

    `KGOC_ASSERT_HOLDS(a_div_done_expected, i_clk, i_rst_n, div_rsp.done, r_issued && div_state, "stray divide")

    `KGOC_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, o_valid && !i_stall && r_state != S_OUT, !o_valid, "word kept")

endmodule
